// File: src/ads_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and saturating helpers for the advection-diffusion stencil.
// Used by ads_pipe and advect_diffuse_stencil; depends on nothing else.

package ads_pkg;

  // Fraction bits of the signed fixed-point format.
  localparam int FRAC_BITS = 16;

  localparam int DATA_W   = 32;
  localparam int H_W      = 31;
  localparam int CFG_IDX_W = 3;
  localparam int IN_W     = 11 * DATA_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_SPACING = 3'd0,
    REG_BASE_DIFF    = 3'd1,
    REG_WIND_GAIN    = 3'd2,
    REG_LENGTH_X     = 3'd3,
    REG_LENGTH_Y     = 3'd4
  } cfg_reg_t;

  localparam logic [H_W-1:0]           GRID_SPACING_RST = 31'd65536;
  localparam logic signed [DATA_W-1:0] COEF_RST         = 32'sd0;

  localparam logic signed [63:0] Q_MAX64 = 64'sd2147483647;
  localparam logic signed [63:0] Q_MIN64 = -64'sd2147483648;

  typedef struct packed {
    logic [H_W-1:0]           grid_spacing;
    logic signed [DATA_W-1:0] base_diffusivity;
    logic signed [DATA_W-1:0] wind_diffusion_gain;
    logic signed [DATA_W-1:0] length_scale_x;
    logic signed [DATA_W-1:0] length_scale_y;
  } ads_cfg_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] t_center;
    logic signed [DATA_W-1:0] t_west2;
    logic signed [DATA_W-1:0] t_west1;
    logic signed [DATA_W-1:0] t_east1;
    logic signed [DATA_W-1:0] t_east2;
    logic signed [DATA_W-1:0] t_south2;
    logic signed [DATA_W-1:0] t_south1;
    logic signed [DATA_W-1:0] t_north1;
    logic signed [DATA_W-1:0] t_north2;
    logic signed [DATA_W-1:0] vel_x;
    logic signed [DATA_W-1:0] vel_y;
  } ads_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] rhs_value;
    logic                     saturated;
  } ads_out_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] val;
    logic                     hit;
  } sat_t;

  // Clip to the signed 32-bit range and flag the clip.
  function automatic sat_t sat64(input logic signed [63:0] v);
    sat_t r;
    if (v > Q_MAX64) begin
      r.val = 32'sh7FFF_FFFF;
      r.hit = 1'b1;
    end else if (v < Q_MIN64) begin
      r.val = 32'sh8000_0000;
      r.hit = 1'b1;
    end else begin
      r.val = v[DATA_W-1:0];
      r.hit = 1'b0;
    end
    return r;
  endfunction

  // Rescale an exact product back to the fixed-point format, rounding toward
  // minus infinity, then saturate.
  function automatic sat_t mulq(input logic signed [63:0] p);
    logic signed [63:0] sh;
    sh = p >>> FRAC_BITS;
    return sat64(sh);
  endfunction

endpackage

// File: src/ads_pipe.sv
`timescale 1ns / 1ps
// Six-stage arithmetic pipeline of the advection-diffusion stencil, x and y lanes side by side.
// Depends on ads_pkg for types and saturating helpers.

module ads_pipe (
  input  logic             clk,
  input  logic             rst_n,
  input  ads_pkg::ads_cfg_t cfg,
  input  logic             in_valid,
  output logic             in_ready,
  input  ads_pkg::ads_in_t in_item,
  output logic             out_valid,
  input  logic             out_ready,
  output ads_pkg::ads_out_t out_item
);

  // floor(c / 3) for a 19-bit value, by reciprocal multiply.
  function automatic logic [17:0] div3_19(input logic [18:0] c);
    logic [37:0] pr;
    pr = {19'd0, c} * 38'd174763;
    return pr[36:19];
  endfunction

  // Stage valid bits and load enables; a stage loads when empty or when its
  // successor loads, so bubbles are squeezed out during a stall.
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic en1, en2, en3, en4, en5, en6;

  assign en6 = !v6_r || out_ready;
  assign en5 = !v5_r || en6;
  assign en4 = !v4_r || en5;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
      if (en5) v5_r <= v4_r;
      if (en6) v6_r <= v5_r;
    end
  end

  // ---------------- stage 1: gain products, second differences, upwind sums
  logic signed [63:0] pg1_r   [2];
  logic signed [31:0] d2_1_r  [2];
  logic [35:0]        u1_r    [2];
  logic signed [31:0] vel1_r  [2];
  logic               hit1_r;

  logic signed [63:0] pg1_nxt  [2];
  logic signed [31:0] d2_1_nxt [2];
  logic [35:0]        u1_nxt   [2];
  logic signed [31:0] vel1_nxt [2];
  logic               hit1_nxt;

  always_comb begin
    logic signed [35:0] cm, m1, m2, p1, p2, s, hv;
    ads_pkg::sat_t      d2s;
    hit1_nxt    = 1'b0;
    vel1_nxt[0] = in_item.vel_x;
    vel1_nxt[1] = in_item.vel_y;
    cm = 36'(in_item.t_center);
    for (int a = 0; a < 2; a++) begin
      if (a == 0) begin
        m2 = 36'(in_item.t_west2);
        m1 = 36'(in_item.t_west1);
        p1 = 36'(in_item.t_east1);
        p2 = 36'(in_item.t_east2);
      end else begin
        m2 = 36'(in_item.t_south2);
        m1 = 36'(in_item.t_south1);
        p1 = 36'(in_item.t_north1);
        p2 = 36'(in_item.t_north2);
      end
      pg1_nxt[a] = cfg.wind_diffusion_gain * vel1_nxt[a];
      d2s = ads_pkg::sat64(64'(p1 + m1 - (cm <<< 1)));
      d2_1_nxt[a] = d2s.val;
      hit1_nxt = hit1_nxt | d2s.hit;
      if (!vel1_nxt[a][31] && (vel1_nxt[a] != 32'sd0)) begin
        s = (p1 <<< 1) + cm * 36'sd3 - m1 * 36'sd6 + m2;
      end else begin
        s = -((m1 <<< 1) + cm * 36'sd3 - p1 * 36'sd6 + p2);
      end
      // floor(s / 6) = floor(floor(s / 2) / 3); the offset of 3 * 2^34 keeps
      // the dividend positive and is taken back out as 2^34 after dividing.
      hv = s >>> 1;
      u1_nxt[a] = hv + 36'hC_0000_0000;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      pg1_r  <= pg1_nxt;
      d2_1_r <= d2_1_nxt;
      u1_r   <= u1_nxt;
      vel1_r <= vel1_nxt;
      hit1_r <= hit1_nxt;
    end
  end

  // ---------------- stage 2: times length scale, divide by three (partials)
  logic signed [63:0] pl2_r  [2];
  logic [34:0]        pq2_r  [2];
  logic [17:0]        cq2_r  [2];
  logic signed [31:0] d2_2_r [2];
  logic signed [31:0] vel2_r [2];
  logic               hit2_r;

  logic signed [63:0] pl2_nxt [2];
  logic [34:0]        pq2_nxt [2];
  logic [17:0]        cq2_nxt [2];
  logic               hit2_nxt;

  always_comb begin
    ads_pkg::sat_t      w;
    logic signed [31:0] len;
    logic [17:0]        hi, lo;
    hit2_nxt = hit1_r;
    for (int a = 0; a < 2; a++) begin
      len = (a == 0) ? cfg.length_scale_x : cfg.length_scale_y;
      w = ads_pkg::mulq(pg1_r[a]);
      hit2_nxt = hit2_nxt | w.hit;
      pl2_nxt[a] = w.val * len;
      // 2^18 is one more than a multiple of three, so the high half divides
      // exactly by (2^18 - 1) / 3 and the remainder joins the low half.
      hi = u1_r[a][35:18];
      lo = u1_r[a][17:0];
      pq2_nxt[a] = {17'd0, hi} * 35'd87381;
      cq2_nxt[a] = div3_19({1'b0, hi} + {1'b0, lo});
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      pl2_r  <= pl2_nxt;
      pq2_r  <= pq2_nxt;
      cq2_r  <= cq2_nxt;
      d2_2_r <= d2_1_r;
      vel2_r <= vel1_r;
      hit2_r <= hit2_nxt;
    end
  end

  // ---------------- stage 3: effective diffusivity, upwind gradient
  logic signed [31:0] df3_r  [2];
  logic signed [31:0] g3_r   [2];
  logic signed [31:0] d2_3_r [2];
  logic signed [31:0] vel3_r [2];
  logic               hit3_r;

  logic signed [31:0] df3_nxt [2];
  logic signed [31:0] g3_nxt  [2];
  logic               hit3_nxt;

  always_comb begin
    ads_pkg::sat_t m, d, g;
    logic [35:0]   q;
    hit3_nxt = hit2_r;
    for (int a = 0; a < 2; a++) begin
      m = ads_pkg::mulq(pl2_r[a]);
      d = ads_pkg::sat64(64'(cfg.base_diffusivity) + 64'(m.val));
      q = {1'b0, pq2_r[a]} + {18'd0, cq2_r[a]};
      g = ads_pkg::sat64($signed({28'd0, q}) - 64'sh4_0000_0000);
      df3_nxt[a] = d.val;
      g3_nxt[a]  = g.val;
      hit3_nxt = hit3_nxt | m.hit | d.hit | g.hit;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      df3_r  <= df3_nxt;
      g3_r   <= g3_nxt;
      d2_3_r <= d2_2_r;
      vel3_r <= vel2_r;
      hit3_r <= hit3_nxt;
    end
  end

  // ---------------- stage 4: diffusion product and spacing product
  logic signed [63:0] pd4_r  [2];
  logic signed [63:0] ph4_r  [2];
  logic signed [31:0] vel4_r [2];
  logic               hit4_r;

  logic signed [63:0] pd4_nxt [2];
  logic signed [63:0] ph4_nxt [2];

  always_comb begin
    logic signed [31:0] hs;
    hs = $signed({1'b0, cfg.grid_spacing});
    for (int a = 0; a < 2; a++) begin
      pd4_nxt[a] = df3_r[a] * d2_3_r[a];
      ph4_nxt[a] = hs * g3_r[a];
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      pd4_r  <= pd4_nxt;
      ph4_r  <= ph4_nxt;
      vel4_r <= vel3_r;
      hit4_r <= hit3_r;
    end
  end

  // ---------------- stage 5: diffusion terms, advection product
  logic signed [31:0] diff5_r [2];
  logic signed [63:0] pa5_r   [2];
  logic               hit5_r;

  logic signed [31:0] diff5_nxt [2];
  logic signed [63:0] pa5_nxt   [2];
  logic               hit5_nxt;

  always_comb begin
    ads_pkg::sat_t df, dh;
    hit5_nxt = hit4_r;
    for (int a = 0; a < 2; a++) begin
      df = ads_pkg::mulq(pd4_r[a]);
      dh = ads_pkg::mulq(ph4_r[a]);
      diff5_nxt[a] = df.val;
      pa5_nxt[a]   = vel4_r[a] * dh.val;
      hit5_nxt = hit5_nxt | df.hit | dh.hit;
    end
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      diff5_r <= diff5_nxt;
      pa5_r   <= pa5_nxt;
      hit5_r  <= hit5_nxt;
    end
  end

  // ---------------- stage 6: final sum and output register
  ads_pkg::ads_out_t res6_r;
  ads_pkg::ads_out_t res6_nxt;

  always_comb begin
    ads_pkg::sat_t ax, ay, tot;
    ax  = ads_pkg::mulq(pa5_r[0]);
    ay  = ads_pkg::mulq(pa5_r[1]);
    tot = ads_pkg::sat64(64'(diff5_r[0]) + 64'(diff5_r[1]) - 64'(ax.val) - 64'(ay.val));
    res6_nxt.rhs_value = tot.val;
    res6_nxt.saturated = hit5_r | ax.hit | ay.hit | tot.hit;
  end

  always_ff @(posedge clk) begin
    if (en6) begin
      res6_r <= res6_nxt;
    end
  end

  assign out_valid = v6_r;
  assign out_item  = res6_r;

endmodule

// File: src/advect_diffuse_stencil.sv
`timescale 1ns / 1ps
// Top level of the advection-diffusion stencil: configuration registers and stream ports.
// Depends on ads_pkg and ads_pipe.

// One stencil result per cell word: diffusivity-weighted second differences minus the
// velocity-weighted third-order upwind gradient, scaled by the grid spacing, in saturating
// signed fixed point. The block takes one word every clock cycle unless an output stall
// backs up to the input. Each accepted word passes through the six register stages of the
// arithmetic pipeline to the output, with no more than two full-width multipliers per lane
// in any stage. A stage holds only while the stage after it is full and holding, so a stall
// on the output backs up without losing or repeating words. The user must write the
// configuration registers only while no word is in flight; the block does not enforce it.

module advect_diffuse_stencil (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_wr_en,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  input  logic         in_tvalid,
  output logic         in_tready,
  // t_center, t_west2, t_west1, t_east1, t_east2, t_south2, t_south1, t_north1,
  // t_north2, vel_x, vel_y (32 bits each, lowest bits first)
  input  logic [351:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // rhs_value
  output logic [31:0]  out_tdata,
  // saturated
  output logic [0:0]   out_tuser
);

  ads_pkg::ads_cfg_t cfg_r;
  ads_pkg::ads_in_t  in_item;
  ads_pkg::ads_out_t out_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.grid_spacing        <= ads_pkg::GRID_SPACING_RST;
      cfg_r.base_diffusivity    <= ads_pkg::COEF_RST;
      cfg_r.wind_diffusion_gain <= ads_pkg::COEF_RST;
      cfg_r.length_scale_x      <= ads_pkg::COEF_RST;
      cfg_r.length_scale_y      <= ads_pkg::COEF_RST;
    end else if (cfg_wr_en) begin
      case (ads_pkg::cfg_reg_t'(cfg_index))
        ads_pkg::REG_GRID_SPACING: cfg_r.grid_spacing        <= cfg_data[30:0];
        ads_pkg::REG_BASE_DIFF:    cfg_r.base_diffusivity    <= cfg_data;
        ads_pkg::REG_WIND_GAIN:    cfg_r.wind_diffusion_gain <= cfg_data;
        ads_pkg::REG_LENGTH_X:     cfg_r.length_scale_x      <= cfg_data;
        ads_pkg::REG_LENGTH_Y:     cfg_r.length_scale_y      <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_item.t_center = in_tdata[31:0];
  assign in_item.t_west2  = in_tdata[63:32];
  assign in_item.t_west1  = in_tdata[95:64];
  assign in_item.t_east1  = in_tdata[127:96];
  assign in_item.t_east2  = in_tdata[159:128];
  assign in_item.t_south2 = in_tdata[191:160];
  assign in_item.t_south1 = in_tdata[223:192];
  assign in_item.t_north1 = in_tdata[255:224];
  assign in_item.t_north2 = in_tdata[287:256];
  assign in_item.vel_x    = in_tdata[319:288];
  assign in_item.vel_y    = in_tdata[351:320];

  ads_pipe u_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_item   (in_item),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_item  (out_item)
  );

  assign out_tdata    = out_item.rhs_value;
  assign out_tuser[0] = out_item.saturated;

endmodule

// File: bench/stencil_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the advection-diffusion stencil: tracks register writes, predicts each result
// word from the accepted cell word and compares it with the returned word.
// Depends on ads_pkg for the register codes, reset values and the cell layout.

module stencil_checker
  import ads_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_wr_en,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [351:0] in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [31:0]  out_tdata,
  input  logic [0:0]   out_tuser,
  output int           fail_count,
  output int           pending
);

  typedef logic signed [63:0] wide_t;

  localparam wide_t Q_HI = 64'sd2147483647;
  localparam wide_t Q_LO = -64'sd2147483648;

  logic [30:0]        spacing_h;
  logic signed [31:0] diff_base;
  logic signed [31:0] diff_gain;
  logic signed [31:0] len_x;
  logic signed [31:0] len_y;

  ads_out_t rhs_expected[$];

  function automatic wide_t clip_q(input wide_t v, inout logic hit);
    if (v > Q_HI) begin
      hit = 1'b1;
      return Q_HI;
    end
    if (v < Q_LO) begin
      hit = 1'b1;
      return Q_LO;
    end
    return v;
  endfunction

  // Fixed-point product; the arithmetic shift rounds toward minus infinity.
  function automatic wide_t mul_q(input wide_t a, input wide_t b, inout logic hit);
    wide_t p;
    p = a * b;
    p = p >>> FRAC_BITS;
    return clip_q(p, hit);
  endfunction

  // Third-order upwind difference along one axis, scaled by the grid spacing. The stencil
  // is mirrored for zero and negative velocity.
  function automatic wide_t upwind_slope(input wide_t vel, input wide_t tm2, input wide_t tm1,
                                         input wide_t tc, input wide_t tp1, input wide_t tp2,
                                         input wide_t h, inout logic hit);
    wide_t s;
    wide_t q;
    wide_t g;
    if (vel > 0)
      s = 2 * tp1 + 3 * tc - 6 * tm1 + tm2;
    else
      s = -(2 * tm1 + 3 * tc - 6 * tp1 + tp2);
    q = s / 6;
    if (s < 0 && q * 6 != s)
      q = q - 1;
    g = clip_q(q, hit);
    return mul_q(h, g, hit);
  endfunction

  function automatic ads_out_t predict_rhs(input ads_in_t c);
    ads_out_t r;
    logic     hit;
    wide_t    h, ux, uy, tc, t;
    wide_t    dfx, dfy, d2x, d2y, ax, ay, total;
    hit = 1'b0;
    h   = {33'd0, spacing_h};
    ux  = $signed(c.vel_x);
    uy  = $signed(c.vel_y);
    tc  = $signed(c.t_center);

    t   = mul_q(wide_t'(diff_gain), ux, hit);
    t   = mul_q(t, wide_t'(len_x), hit);
    dfx = clip_q(wide_t'(diff_base) + t, hit);
    t   = mul_q(wide_t'(diff_gain), uy, hit);
    t   = mul_q(t, wide_t'(len_y), hit);
    dfy = clip_q(wide_t'(diff_base) + t, hit);

    d2x = clip_q(wide_t'($signed(c.t_east1)) - 2 * tc + wide_t'($signed(c.t_west1)), hit);
    d2y = clip_q(wide_t'($signed(c.t_north1)) - 2 * tc + wide_t'($signed(c.t_south1)), hit);

    ax = upwind_slope(ux, $signed(c.t_west2), $signed(c.t_west1), tc,
                      $signed(c.t_east1), $signed(c.t_east2), h, hit);
    ay = upwind_slope(uy, $signed(c.t_south2), $signed(c.t_south1), tc,
                      $signed(c.t_north1), $signed(c.t_north2), h, hit);

    // The four terms are clipped one by one, their sum is formed exactly.
    total = mul_q(dfx, d2x, hit);
    total = total + mul_q(dfy, d2y, hit);
    total = total - mul_q(ux, ax, hit);
    total = total - mul_q(uy, ay, hit);
    total = clip_q(total, hit);

    r.rhs_value = total[31:0];
    r.saturated = hit;
    return r;
  endfunction

  always @(posedge clk) begin
    ads_in_t  word_in;
    ads_out_t want;
    if (!rst_n) begin
      spacing_h  = GRID_SPACING_RST;
      diff_base  = COEF_RST;
      diff_gain  = COEF_RST;
      len_x      = COEF_RST;
      len_y      = COEF_RST;
      fail_count = 0;
      rhs_expected.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_reg_t'(cfg_index))
          REG_GRID_SPACING: spacing_h = cfg_data[30:0];
          REG_BASE_DIFF:    diff_base = cfg_data;
          REG_WIND_GAIN:    diff_gain = cfg_data;
          REG_LENGTH_X:     len_x     = cfg_data;
          REG_LENGTH_Y:     len_y     = cfg_data;
          default: ;
        endcase
      end

      if (in_tvalid && in_tready) begin
        word_in.t_center = in_tdata[0*32 +: 32];
        word_in.t_west2  = in_tdata[1*32 +: 32];
        word_in.t_west1  = in_tdata[2*32 +: 32];
        word_in.t_east1  = in_tdata[3*32 +: 32];
        word_in.t_east2  = in_tdata[4*32 +: 32];
        word_in.t_south2 = in_tdata[5*32 +: 32];
        word_in.t_south1 = in_tdata[6*32 +: 32];
        word_in.t_north1 = in_tdata[7*32 +: 32];
        word_in.t_north2 = in_tdata[8*32 +: 32];
        word_in.vel_x    = in_tdata[9*32 +: 32];
        word_in.vel_y    = in_tdata[10*32 +: 32];
        rhs_expected.push_back(predict_rhs(word_in));
      end

      if (out_tvalid && out_tready) begin
        if (rhs_expected.size() == 0) begin
          $error("result word with nothing expected: rhs_value %0d saturated %0d",
                 $signed(out_tdata), out_tuser[0]);
          fail_count++;
        end else begin
          want = rhs_expected.pop_front();
          if (out_tdata !== want.rhs_value) begin
            $error("rhs_value: expected %0d, actual %0d",
                   $signed(want.rhs_value), $signed(out_tdata));
            fail_count++;
          end
          if (out_tuser[0] !== want.saturated) begin
            $error("saturated: expected %0d, actual %0d", want.saturated, out_tuser[0]);
            fail_count++;
          end
        end
      end
    end
    pending = rhs_expected.size();
  end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// Top of the stencil bench: clock, reset, register writes, cell words and a stalling sink.
// Depends on ads_pkg, advect_diffuse_stencil and stencil_checker.

module testbench;
  import ads_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int PHASE_WORDS  = 325;
  localparam int CFG_SLOTS    = 1 << CFG_IDX_W;

  localparam logic signed [31:0] MAXV = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] MINV = 32'sh8000_0000;
  localparam logic signed [31:0] ONE  = 32'sh0001_0000;

  logic         clk;
  logic         rst_n;
  logic         cfg_wr_en;
  logic [2:0]   cfg_index;
  logic [31:0]  cfg_data;
  logic         in_tvalid;
  logic         in_tready;
  logic [351:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [31:0]  out_tdata;
  logic [0:0]   out_tuser;

  int fail_count;
  int pending;
  int words_sent;
  int burst_left;
  int cycles;

  advect_diffuse_stencil uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  stencil_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // Temperatures mostly sit close to a common level, as in a smooth field.
  function automatic logic signed [31:0] temp_value(input logic signed [31:0] level);
    int span;
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: begin
        case ($urandom_range(0, 3))
          0: return MAXV;
          1: return MINV;
          2: return 32'sd0;
          default: return -32'sd1;
        endcase
      end
      default: begin
        span = $urandom_range(1, 24);
        return level + ($signed($urandom()) >>> (32 - span));
      end
    endcase
  endfunction

  function automatic logic signed [31:0] vel_value();
    case ($urandom_range(0, 7))
      0: return 32'sd0;
      1: begin
        case ($urandom_range(0, 3))
          0: return MAXV;
          1: return MINV;
          2: return 32'sd1;
          default: return -32'sd1;
        endcase
      end
      2: return $urandom();
      default: return $signed($urandom()) >>> $urandom_range(11, 30);
    endcase
  endfunction

  function automatic logic [31:0] coef_value();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return ($urandom_range(0, 1) == 0) ? MAXV : MINV;
      default: return $signed($urandom()) >>> $urandom_range(10, 28);
    endcase
  endfunction

  function automatic ads_in_t random_cell();
    ads_in_t c;
    logic signed [31:0] level;
    level = ($urandom_range(0, 7) == 0) ? $urandom() : ($signed($urandom()) >>> 8);
    c.t_center = temp_value(level);
    c.t_west2  = temp_value(level);
    c.t_west1  = temp_value(level);
    c.t_east1  = temp_value(level);
    c.t_east2  = temp_value(level);
    c.t_south2 = temp_value(level);
    c.t_south1 = temp_value(level);
    c.t_north1 = temp_value(level);
    c.t_north2 = temp_value(level);
    c.vel_x    = vel_value();
    c.vel_y    = vel_value();
    return c;
  endfunction

  // Offers one cell word, opening a new burst after a random gap when the last one ran out.
  task automatic send_cell(input ads_in_t c);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
      if (gap > 0) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {c.vel_y, c.vel_x, c.t_north2, c.t_north1, c.t_south1, c.t_south2,
                  c.t_east2, c.t_east1, c.t_west1, c.t_west2, c.t_center};
    do @(posedge clk); while (!in_tready);
    words_sent++;
  endtask

  // Lets every word in flight come out, then waits on with the input idle before returning.
  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic set_coefs(input logic [31:0] h, input logic [31:0] base,
                           input logic [31:0] gain, input logic [31:0] lx,
                           input logic [31:0] ly);
    settle();
    write_reg(REG_GRID_SPACING, h);
    write_reg(REG_BASE_DIFF, base);
    write_reg(REG_WIND_GAIN, gain);
    write_reg(REG_LENGTH_X, lx);
    write_reg(REG_LENGTH_Y, ly);
  endtask

  // Sink: segments of different stall patterns, and a long hold-off twice during the run
  // so that the pipeline fills and pushes back on the sender.
  initial begin
    int mode;
    int seg;
    int tick;
    int hold_mark;
    out_tready = 1'b0;
    hold_mark  = 300;
    tick       = 0;
    forever begin
      if (words_sent >= hold_mark) begin
        hold_mark += 900;
        @(negedge clk);
        out_tready <= 1'b0;
        repeat (250) @(negedge clk);
      end
      mode = $urandom_range(0, 3);
      seg  = $urandom_range(16, 96);
      repeat (seg) begin
        @(negedge clk);
        tick++;
        case (mode)
          0: out_tready <= 1'b1;
          1: out_tready <= ($urandom_range(0, 1) == 0);
          2: out_tready <= (tick % 4 == 0);
          default: out_tready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  initial begin
    ads_in_t c;
    rst_n      = 1'b0;
    cfg_wr_en  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    words_sent = 0;
    burst_left = 0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // Directed cells under moderate coefficients: h = 1.0, D0 = 1.0, gain 0.5,
    // lengths 2.0 and -1.0.
    set_coefs(ONE, ONE, ONE >>> 1, 2 * ONE, -ONE);
    for (int k = 0; k < 14; k++) begin
      c = '0;
      case (k)
        1: c = {11{MAXV}};
        2: c = {11{MINV}};
        3, 4, 5, 6: begin
          c.t_west2  = -2 * ONE;
          c.t_west1  = -ONE;
          c.t_center = ONE >>> 2;
          c.t_east1  = ONE;
          c.t_east2  = 4 * ONE;
          c.t_south2 = 3 * ONE;
          c.t_south1 = ONE;
          c.t_north1 = -ONE;
          c.t_north2 = 5;
          case (k)
            3: begin
              c.vel_x = ONE;
              c.vel_y = ONE;
            end
            4: begin
              c.vel_x = -ONE;
              c.vel_y = -ONE;
            end
            5: ;
            default: begin
              c.vel_x = 32'sd1;
              c.vel_y = -32'sd1;
            end
          endcase
        end
        7: begin
          c = {11{MAXV}};
          c.t_center = MINV;
          c.vel_x = 32'sd0;
          c.vel_y = 32'sd0;
        end
        8: begin
          c = {11{MINV}};
          c.t_center = MAXV;
          c.vel_x = MAXV;
        end
        9, 10: begin
          c.t_center = ONE;
          c.t_east1  = 2 * ONE;
          c.t_north2 = -3 * ONE;
          c.vel_x    = (k == 9) ? MAXV : MINV;
          c.vel_y    = (k == 9) ? MAXV : MINV;
        end
        11, 12: begin
          c.t_east1  = (k == 11) ? MAXV : MINV;
          c.t_west1  = (k == 11) ? MINV : MAXV;
          c.t_east2  = (k == 11) ? MINV : MAXV;
          c.t_west2  = (k == 11) ? MAXV : MINV;
          c.t_north1 = (k == 11) ? MINV : MAXV;
          c.t_south1 = (k == 11) ? MAXV : MINV;
          c.t_north2 = (k == 11) ? MAXV : MINV;
          c.t_south2 = (k == 11) ? MINV : MAXV;
          c.vel_x    = ONE;
          c.vel_y    = -ONE;
        end
        13: c = {{5{32'hAAAA_AAAA, 32'h5555_5555}}, 32'hAAAA_AAAA};
        default: ;
      endcase
      send_cell(c);
    end

    // Zero grid spacing removes the advection terms; writes to unused indexes change nothing.
    settle();
    write_reg(REG_GRID_SPACING, 32'd0);
    for (int k = REG_LENGTH_Y + 1; k < CFG_SLOTS; k++)
      write_reg(3'(k), 32'hFFFF_FFFF);
    repeat (6) send_cell(random_cell());

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: set_coefs(GRID_SPACING_RST, COEF_RST, COEF_RST, COEF_RST, COEF_RST);
        1: set_coefs(32'h7FFF_FFFF, MAXV, MAXV, MAXV, MINV);
        2: set_coefs(32'd1, MINV, MINV, MINV, MAXV);
        3: set_coefs($urandom_range(1, 1 << 18), coef_value(), coef_value(),
                     coef_value(), coef_value());
        4: set_coefs($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
        default: set_coefs($urandom_range(0, 1 << 20), coef_value(), coef_value(),
                           coef_value(), coef_value());
      endcase
      repeat (PHASE_WORDS) send_cell(random_cell());
    end

    settle();
    if (fail_count == 0 && pending == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
